### src/pm_frame_checksum_accumulator_top_macros.svh
// -----------------------------------------------------------------------------
// Assertion macros for the frame checksum accumulator
// Immediate-consequence and next-cycle checks on the i_clk domain.
// -----------------------------------------------------------------------------
`ifndef PM_FRAME_CHECKSUM_ACCUMULATOR_TOP_MACROS_SVH
`define PM_FRAME_CHECKSUM_ACCUMULATOR_TOP_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define PFCA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define PFCA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/pfca_pkg.sv
// -----------------------------------------------------------------------------
// pfca_pkg
// Shared types and constants of the frame checksum accumulator.
// -----------------------------------------------------------------------------
package pfca_pkg;

    localparam int FRAME_BYTES = 29;
    localparam int POS_W       = 6;
    localparam int PM_W        = 16;
    localparam int SUM_W       = 24;
    localparam int CNT_W       = 8;
    localparam int FRAC_W      = 4;
    localparam int MEAN_W      = 20;
    localparam int DIV_BITS    = SUM_W + FRAC_W;
    localparam int DIV_CW      = $clog2(DIV_BITS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] ID_OFS   = POS_W'(2);
    localparam logic [POS_W-1:0] PM1_OFS  = POS_W'(10);
    localparam logic [POS_W-1:0] PM25_OFS = POS_W'(12);
    localparam logic [POS_W-1:0] PM10_OFS = POS_W'(14);

    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_ABORT = 2'd1,
        OP_CLOSE = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        FS_ACCEPTED = 2'd0,
        FS_MISMATCH = 2'd1,
        FS_ABORTED  = 2'd2
    } t_status;

    typedef enum logic {
        KIND_STATUS  = 1'b0,
        KIND_SUMMARY = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        CMD_GOOD  = 2'd0,
        CMD_BAD   = 2'd1,
        CMD_ABORT = 2'd2,
        CMD_CLOSE = 2'd3
    } t_cmd_op;

    // Command from the front end to the back end.
    typedef struct packed {
        t_cmd_op                op;
        logic [PM_W-1:0]        sensor_id;
        logic [2:0][PM_W-1:0]   pm;
    } t_cmd;

    // One result beat.
    typedef struct packed {
        t_kind                  kind;
        t_status                status;
        logic [PM_W-1:0]        sensor_id;
        logic [CNT_W-1:0]       samples;
        logic [2:0][MEAN_W-1:0] mean;
        logic [2:0][PM_W-1:0]   peak;
    } t_result;

endpackage

### src/pfca_front.sv
// -----------------------------------------------------------------------------
// pfca_front
// Frame parser: tracks byte position and checksum, captures the sensor number
// and PM values, and issues one command per item that yields a result.
// -----------------------------------------------------------------------------
module pfca_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [1:0]            i_operation,
    input  logic [7:0]            i_data_byte,
    output logic                  o_push,
    output pfca_pkg::t_cmd        o_cmd
);
    import pfca_pkg::*;

    logic [POS_W-1:0]      r_pos;
    logic [7:0]            r_sum;
    logic [3:0][PM_W-1:0]  r_pend;

    logic [POS_W-1:0]      w_pos_even;
    logic                  w_hit;
    logic [1:0]            w_slot;
    logic                  w_emit;
    logic                  w_advance;
    logic                  w_clear;
    t_cmd_op               w_op;

    // Map the even byte of a value pair to its pending slot.
    always_comb begin
        w_pos_even = {r_pos[POS_W-1:1], 1'b0};
        w_hit      = 1'b1;
        w_slot     = 2'd0;
        if (w_pos_even == ID_OFS) begin
            w_slot = 2'd0;
        end else if (w_pos_even == PM1_OFS) begin
            w_slot = 2'd1;
        end else if (w_pos_even == PM25_OFS) begin
            w_slot = 2'd2;
        end else if (w_pos_even == PM10_OFS) begin
            w_slot = 2'd3;
        end else begin
            w_hit = 1'b0;
        end
    end

    always_comb begin
        w_emit    = 1'b0;
        w_advance = 1'b0;
        w_clear   = 1'b0;
        w_op      = CMD_CLOSE;
        case (t_op'(i_operation))
            OP_BYTE: begin
                if (r_pos < LAST_POS) begin
                    w_advance = 1'b1;
                end else begin
                    w_emit  = 1'b1;
                    w_clear = 1'b1;
                    w_op    = (i_data_byte == r_sum) ? CMD_GOOD : CMD_BAD;
                end
            end
            OP_ABORT: begin
                if (r_pos != '0) begin
                    w_emit  = 1'b1;
                    w_clear = 1'b1;
                    w_op    = CMD_ABORT;
                end
            end
            OP_CLOSE: begin
                w_emit = 1'b1;
                w_op   = CMD_CLOSE;
            end
            default: begin
            end
        endcase
    end

    assign o_push          = i_accept && w_emit;
    assign o_cmd.op        = w_op;
    assign o_cmd.sensor_id = r_pend[0];
    assign o_cmd.pm        = {r_pend[3], r_pend[2], r_pend[1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_sum  <= '0;
            r_pend <= '0;
        end else if (i_accept) begin
            if (w_advance) begin
                if (w_hit) begin
                    if (!r_pos[0]) begin
                        r_pend[w_slot][15:8] <= i_data_byte;
                    end else begin
                        r_pend[w_slot][7:0] <= i_data_byte;
                    end
                end
                r_sum <= r_sum + i_data_byte;
                r_pos <= r_pos + POS_W'(1);
            end else if (w_clear) begin
                r_pos <= '0;
                r_sum <= '0;
            end
        end
    end

endmodule

### src/pfca_queue.sv
// -----------------------------------------------------------------------------
// pfca_queue
// Short command queue between the frame parser and the window engine.
// -----------------------------------------------------------------------------
module pfca_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  pfca_pkg::t_cmd        i_cmd,
    input  logic                  i_pop,
    output logic                  o_full,
    output logic                  o_empty,
    output pfca_pkg::t_cmd        o_head
);
    import pfca_pkg::*;

    t_cmd                  r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr;
    logic [QUEUE_AW-1:0]   r_rd;
    logic [QUEUE_AW:0]     r_cnt;

    assign o_full  = (r_cnt == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QUEUE_AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + (QUEUE_AW + 1)'(1);
                2'b01:   r_cnt <= r_cnt - (QUEUE_AW + 1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### src/pfca_back.sv
// -----------------------------------------------------------------------------
// pfca_back
// Window engine: applies frame verdicts to the window sums and peaks, and on
// close runs a bit-serial divider for the three means before reporting.
// -----------------------------------------------------------------------------
module pfca_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_empty,
    input  pfca_pkg::t_cmd        i_cmd,
    output logic                  o_q_pop,
    input  logic                  i_pop,
    output logic                  o_valid,
    output pfca_pkg::t_result     o_result
);
    import pfca_pkg::*;

    typedef enum logic [2:0] {
        BS_IDLE = 3'b001,
        BS_DIV  = 3'b010,
        BS_DONE = 3'b100
    } t_bstate;

    t_bstate                  r_state;
    logic                     r_out_valid;
    t_result                  r_out;

    logic [2:0][SUM_W-1:0]    r_sum;
    logic [2:0][PM_W-1:0]     r_peak;
    logic [CNT_W-1:0]         r_count;
    logic [PM_W-1:0]          r_id;

    logic [2:0][DIV_BITS-1:0] r_num;
    logic [2:0][7:0]          r_rem;
    logic [CNT_W-1:0]         r_den;
    logic [DIV_CW-1:0]        r_step;
    logic [PM_W-1:0]          r_snap_id;
    logic [2:0][PM_W-1:0]     r_snap_peak;

    logic                     w_out_free;
    logic                     w_take;
    logic                     w_not_sat;
    logic [2:0][DIV_BITS-1:0] w_num_nx;
    logic [2:0][7:0]          w_rem_nx;
    logic [8:0]               w_rem_sh [3];
    logic                     w_ge [3];
    t_result                  w_status_res;
    t_result                  w_summary;

    assign w_out_free = !r_out_valid || i_pop;
    assign w_take     = (r_state == BS_IDLE) && !i_q_empty && w_out_free;
    assign w_not_sat  = (r_count != {CNT_W{1'b1}});
    assign o_q_pop    = w_take;
    assign o_valid    = r_out_valid;
    assign o_result   = r_out;

    // One restoring-division step per lane.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_rem_sh[i] = {r_rem[i], r_num[i][DIV_BITS-1]};
            w_ge[i]     = (w_rem_sh[i] >= {1'b0, r_den});
            w_rem_nx[i] = w_ge[i] ? 8'(w_rem_sh[i] - {1'b0, r_den}) : w_rem_sh[i][7:0];
            w_num_nx[i] = {r_num[i][DIV_BITS-2:0], w_ge[i]};
        end
    end

    always_comb begin
        w_status_res      = '0;
        w_status_res.kind = KIND_STATUS;
        case (i_cmd.op)
            CMD_GOOD:  w_status_res.status = FS_ACCEPTED;
            CMD_BAD:   w_status_res.status = FS_MISMATCH;
            CMD_ABORT: w_status_res.status = FS_ABORTED;
            default:   w_status_res.status = FS_ACCEPTED;
        endcase

        w_summary           = '0;
        w_summary.kind      = KIND_SUMMARY;
        w_summary.status    = FS_ACCEPTED;
        w_summary.sensor_id = r_snap_id;
        w_summary.samples   = r_den;
        w_summary.peak      = r_snap_peak;
        for (int i = 0; i < 3; i++) begin
            w_summary.mean[i] = (r_den == '0) ? '0 : r_num[i][MEAN_W-1:0];
        end
    end

    // Control and window state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_out_valid <= 1'b0;
            r_sum       <= '0;
            r_peak      <= '0;
            r_count     <= '0;
            r_id        <= '0;
            r_step      <= '0;
        end else begin
            if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                BS_IDLE: begin
                    if (w_take) begin
                        case (i_cmd.op)
                            CMD_GOOD: begin
                                r_id <= i_cmd.sensor_id;
                                for (int i = 0; i < 3; i++) begin
                                    if (w_not_sat) begin
                                        r_sum[i] <= r_sum[i] + SUM_W'(i_cmd.pm[i]);
                                    end
                                    if (i_cmd.pm[i] > r_peak[i]) begin
                                        r_peak[i] <= i_cmd.pm[i];
                                    end
                                end
                                if (w_not_sat) begin
                                    r_count <= r_count + CNT_W'(1);
                                end
                                r_out_valid <= 1'b1;
                            end
                            CMD_BAD, CMD_ABORT: begin
                                r_out_valid <= 1'b1;
                            end
                            CMD_CLOSE: begin
                                // snapshot is taken in the datapath block; drop window
                                r_sum   <= '0;
                                r_peak  <= '0;
                                r_count <= '0;
                                r_id    <= '0;
                                r_step  <= '0;
                                r_state <= BS_DIV;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                BS_DIV: begin
                    r_step <= r_step + DIV_CW'(1);
                    if (r_step == DIV_CW'(DIV_BITS - 1)) begin
                        r_state <= BS_DONE;
                    end
                end
                BS_DONE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= BS_IDLE;
                    end
                end
                default: r_state <= BS_IDLE;
            endcase
        end
    end

    // Datapath: result register, divider and summary snapshot.
    always_ff @(posedge i_clk) begin
        case (r_state)
            BS_IDLE: begin
                if (w_take) begin
                    if (i_cmd.op == CMD_CLOSE) begin
                        for (int i = 0; i < 3; i++) begin
                            r_num[i] <= {r_sum[i], {FRAC_W{1'b0}}};
                            r_rem[i] <= '0;
                        end
                        r_den       <= r_count;
                        r_snap_id   <= r_id;
                        r_snap_peak <= r_peak;
                    end else begin
                        r_out <= w_status_res;
                    end
                end
            end
            BS_DIV: begin
                r_num <= w_num_nx;
                r_rem <= w_rem_nx;
            end
            BS_DONE: begin
                if (w_out_free) begin
                    r_out <= w_summary;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

### src/pm_frame_checksum_accumulator_top.sv
// -----------------------------------------------------------------------------
// pm_frame_checksum_accumulator_top
// Particle-sensor frame checker with window statistics.
// -----------------------------------------------------------------------------
// Input channel: push/full. Each beat carries i_operation (frame byte, abort,
// close) and i_data_byte. A beat is taken when push is high and full is low.
// Result channel: empty/pop. The oldest result sits on the o_* ports while
// empty is low and leaves on a rising edge with pop high.
// A frame byte that is not the last of its frame yields no result. The last
// byte, an abort of a partial frame and a close each yield one result.
// Path: each beat's command passes through the command queue to the window
// engine, which writes a frame status into the result register; a close first
// runs the 28-step bit-serial divider that computes the three means side by
// side. Throughput: one beat per cycle while full is low; the 2-entry command
// queue between the parser and the window engine absorbs commands while a
// summary divides, and full rises only when that queue fills.
// Reset (synchronous, active low) clears the frame position, checksum, window
// sums, peaks, count and sensor number, and empties queue and result register.
// When the receiver stalls, the result register holds, the queue fills, and
// full then holds off the sender; no result is lost or repeated.
// -----------------------------------------------------------------------------
module pm_frame_checksum_accumulator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_data_byte,
    output logic        empty,
    input  logic        pop,
    output logic        o_kind,
    output logic [1:0]  o_frame_status,
    output logic [15:0] o_sensor_id,
    output logic [7:0]  o_samples_in_window,
    output logic [19:0] o_pm1_mean,
    output logic [15:0] o_pm1_peak,
    output logic [19:0] o_pm25_mean,
    output logic [15:0] o_pm25_peak,
    output logic [19:0] o_pm10_mean,
    output logic [15:0] o_pm10_peak
);
    import pfca_pkg::*;

    logic    w_accept;
    logic    w_q_push;
    logic    w_q_full;
    logic    w_q_pop;
    logic    w_q_empty;
    t_cmd    w_front_cmd;
    t_cmd    w_q_head;
    logic    w_out_valid;
    t_result w_result;
    logic    w_status_pop;
    logic    w_status_out;
    logic    w_status_clean;

    // Take a beat only while the command queue has room.
    assign w_accept = push && !w_q_full;
    assign full     = w_q_full;

    pfca_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_operation (i_operation),
        .i_data_byte (i_data_byte),
        .o_push      (w_q_push),
        .o_cmd       (w_front_cmd)
    );

    pfca_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_cmd   (w_front_cmd),
        .i_pop   (w_q_pop),
        .o_full  (w_q_full),
        .o_empty (w_q_empty),
        .o_head  (w_q_head)
    );

    pfca_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_q_empty),
        .i_cmd     (w_q_head),
        .o_q_pop   (w_q_pop),
        .i_pop     (pop && w_out_valid),
        .o_valid   (w_out_valid),
        .o_result  (w_result)
    );

    // Unpack the result register onto the field ports.
    assign empty               = !w_out_valid;
    assign o_kind              = w_result.kind;
    assign o_frame_status      = w_result.status;
    assign o_sensor_id         = w_result.sensor_id;
    assign o_samples_in_window = w_result.samples;
    assign o_pm1_mean          = w_result.mean[0];
    assign o_pm1_peak          = w_result.peak[0];
    assign o_pm25_mean         = w_result.mean[1];
    assign o_pm25_peak         = w_result.peak[1];
    assign o_pm10_mean         = w_result.mean[2];
    assign o_pm10_peak         = w_result.peak[2];

    // Terms for the checks below.
    assign w_status_pop   = w_q_pop && (w_q_head.op != CMD_CLOSE);
    assign w_status_out   = !empty && (o_kind == KIND_STATUS);
    assign w_status_clean = (o_sensor_id == '0) && (o_samples_in_window == '0);

`include "pm_frame_checksum_accumulator_top_macros.svh"

    `PFCA_ASSERT_SAME(a_queue_no_overflow, w_q_push, !w_q_full, "push into full queue")
    `PFCA_ASSERT_SAME(a_queue_no_underflow, w_q_pop, !w_q_empty, "pop from empty queue")
    `PFCA_ASSERT_NEXT(a_status_follows_cmd, w_status_pop, !empty, "status result missing")
    `PFCA_ASSERT_SAME(a_status_fields_zero, w_status_out, w_status_clean, "status with window data")

endmodule

### test/testbench.sv
// -----------------------------------------------------------------------------
// testbench
// Self-checking bench for the particle-sensor frame checksum accumulator.
// A local predictor tracks frame position, checksum and window statistics for
// every accepted beat and queues the status or summary result it should see.
// The result side compares each popped beat field by field with the oldest
// queued result. Directed tests cover empty windows, abort with nothing to
// drop, the unused code, checksum failures, a close inside a frame and count
// saturation. A long receiver stall and random traffic follow.
// -----------------------------------------------------------------------------
module testbench;
    import pfca_pkg::*;

    // Unused operation code: the block must ignore it.
    localparam logic [1:0] OP_SPARE = 2'd3;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 40;      // margin for the summary divider
    localparam int RANDOM_ITEMS = 2000;
    localparam int STEADY_ITEMS = 400;     // opening random stretch with no idling
    localparam int HOLD_CYCLES  = 400;     // long receiver stall

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        push        = 1'b0;
    logic        pop         = 1'b0;
    logic [1:0]  i_operation = OP_BYTE;
    logic [7:0]  i_data_byte = 8'h00;
    logic        full;
    logic        empty;
    logic        o_kind;
    logic [1:0]  o_frame_status;
    logic [15:0] o_sensor_id;
    logic [7:0]  o_samples_in_window;
    logic [19:0] o_pm1_mean;
    logic [15:0] o_pm1_peak;
    logic [19:0] o_pm25_mean;
    logic [15:0] o_pm25_peak;
    logic [19:0] o_pm10_mean;
    logic [15:0] o_pm10_peak;

    always #5 i_clk = ~i_clk;

    pm_frame_checksum_accumulator_top i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .push                (push),
        .full                (full),
        .i_operation         (i_operation),
        .i_data_byte         (i_data_byte),
        .empty               (empty),
        .pop                 (pop),
        .o_kind              (o_kind),
        .o_frame_status      (o_frame_status),
        .o_sensor_id         (o_sensor_id),
        .o_samples_in_window (o_samples_in_window),
        .o_pm1_mean          (o_pm1_mean),
        .o_pm1_peak          (o_pm1_peak),
        .o_pm25_mean         (o_pm25_mean),
        .o_pm25_peak         (o_pm25_peak),
        .o_pm10_mean         (o_pm10_mean),
        .o_pm10_peak         (o_pm10_peak)
    );

    // -------------------------------------------------------------------------
    // Predictor state: frame in progress and window statistics.
    // -------------------------------------------------------------------------
    logic [POS_W-1:0] frm_pos  = '0;
    logic [7:0]       frm_sum  = '0;
    logic [PM_W-1:0]  frm_val [4] = '{default: '0};   // id, pm1, pm25, pm10
    logic [SUM_W-1:0] win_sum [3] = '{default: '0};
    logic [PM_W-1:0]  win_peak[3] = '{default: '0};
    logic [CNT_W-1:0] win_cnt  = '0;
    logic [PM_W-1:0]  win_id   = '0;

    t_result due_results[$];

    // Bench bookkeeping.
    int items_sent  = 0;
    int mismatches  = 0;
    int n_good      = 0;
    int n_bad       = 0;
    int n_abort     = 0;
    int n_summary   = 0;
    int cycle_count = 0;
    int rx_hold     = 0;
    bit tx_steady   = 1'b0;
    bit rx_steady   = 1'b0;

    // Advance the predictor by one accepted beat; queue the result it causes.
    task automatic track_beat(input logic [1:0] op, input logic [7:0] data);
        t_result                 r;
        int                      s;
        logic [DIV_BITS-1:0]     scaled;
        r = '0;
        case (op)
            OP_BYTE: begin
                if (frm_pos < LAST_POS) begin
                    if (frm_pos == ID_OFS || frm_pos == ID_OFS + 1)          s = 0;
                    else if (frm_pos == PM1_OFS || frm_pos == PM1_OFS + 1)   s = 1;
                    else if (frm_pos == PM25_OFS || frm_pos == PM25_OFS + 1) s = 2;
                    else if (frm_pos == PM10_OFS || frm_pos == PM10_OFS + 1) s = 3;
                    else                                                     s = -1;
                    // Values are big-endian: even positions carry the high byte.
                    if (s >= 0) begin
                        if (frm_pos[0] == 1'b0) frm_val[s][15:8] = data;
                        else                    frm_val[s][7:0]  = data;
                    end
                    frm_sum = frm_sum + data;
                    frm_pos = frm_pos + 1'b1;
                end else begin
                    r.kind = KIND_STATUS;
                    if (data == frm_sum) begin
                        r.status = FS_ACCEPTED;
                        win_id = frm_val[0];
                        // Once the count saturates, peaks still move but sums hold.
                        for (int i = 0; i < 3; i++) begin
                            if (win_cnt != 8'd255) win_sum[i] = win_sum[i] + frm_val[i+1];
                            if (frm_val[i+1] > win_peak[i]) win_peak[i] = frm_val[i+1];
                        end
                        if (win_cnt != 8'd255) win_cnt = win_cnt + 1'b1;
                    end else begin
                        r.status = FS_MISMATCH;
                    end
                    frm_pos = '0;
                    frm_sum = '0;
                    due_results.push_back(r);
                end
            end
            OP_ABORT: begin
                // Nothing to drop at the start of a frame: no result.
                if (frm_pos != '0) begin
                    frm_pos  = '0;
                    frm_sum  = '0;
                    r.kind   = KIND_STATUS;
                    r.status = FS_ABORTED;
                    due_results.push_back(r);
                end
            end
            OP_CLOSE: begin
                // A close leaves the frame in progress alone.
                r.kind      = KIND_SUMMARY;
                r.status    = FS_ACCEPTED;
                r.sensor_id = win_id;
                r.samples   = win_cnt;
                for (int i = 0; i < 3; i++) begin
                    scaled = '0;
                    if (win_cnt != '0) scaled = {win_sum[i], {FRAC_W{1'b0}}} / win_cnt;
                    r.mean[i] = scaled[MEAN_W-1:0];
                    r.peak[i] = win_peak[i];
                    win_sum[i]  = '0;
                    win_peak[i] = '0;
                end
                win_cnt = '0;
                win_id  = '0;
                due_results.push_back(r);
            end
            default: ;  // spare code: ignored
        endcase
    endtask

    // -------------------------------------------------------------------------
    // Sender: drive at the falling edge, take acceptance at the rising edge.
    // -------------------------------------------------------------------------
    task automatic send_beat(input logic [1:0] op, input logic [7:0] data);
        while (!tx_steady && $urandom_range(99) < 33) begin
            @(negedge i_clk);
            push <= 1'b0;
        end
        @(negedge i_clk);
        push        <= 1'b1;
        i_operation <= op;
        i_data_byte <= data;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        track_beat(op, data);
        if (op != OP_SPARE) items_sent++;
    endtask

    // Send one whole frame; optionally corrupt the checksum or close mid-frame.
    task automatic send_frame(input logic [15:0] id, input logic [15:0] p1,
                              input logic [15:0] p25, input logic [15:0] p10,
                              input bit corrupt, input bit rand_fill,
                              input logic [7:0] fill, input int close_at);
        logic [7:0] sum;
        logic [7:0] b;
        sum = '0;
        for (int i = 0; i < FRAME_BYTES - 1; i++) begin
            case (i)
                ID_OFS:       b = id[15:8];
                ID_OFS + 1:   b = id[7:0];
                PM1_OFS:      b = p1[15:8];
                PM1_OFS + 1:  b = p1[7:0];
                PM25_OFS:     b = p25[15:8];
                PM25_OFS + 1: b = p25[7:0];
                PM10_OFS:     b = p10[15:8];
                PM10_OFS + 1: b = p10[7:0];
                default:      b = rand_fill ? 8'($urandom) : fill;
            endcase
            sum = sum + b;
            send_beat(OP_BYTE, b);
            if (i == close_at) send_beat(OP_CLOSE, 8'($urandom));
        end
        if (corrupt) sum = sum ^ 8'($urandom_range(1, 255));
        send_beat(OP_BYTE, sum);
    endtask

    function automatic logic [15:0] rand_pm();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) return 16'h0000;
        if (pick == 1) return 16'hFFFF;
        return 16'($urandom);
    endfunction

    // Pause the sender until every queued result has come out.
    task automatic wait_for_results();
        @(negedge i_clk);
        push <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // -------------------------------------------------------------------------
    // Receiver: pop at random, or hold off for a counted stretch.
    // -------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            pop <= 1'b0;
            rx_hold = rx_hold - 1;
        end else begin
            pop <= rx_steady || ($urandom_range(99) >= 33);
        end
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    t_result head;

    // Compare each popped beat against the oldest queued result.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (due_results.size() == 0) begin
                report_mismatch("result beat with nothing queued");
            end else begin
                head = due_results.pop_front();
                check_field("kind",      o_kind,              head.kind);
                check_field("status",    o_frame_status,      head.status);
                check_field("sensor_id", o_sensor_id,         head.sensor_id);
                check_field("samples",   o_samples_in_window, head.samples);
                check_field("pm1_mean",  o_pm1_mean,          head.mean[0]);
                check_field("pm1_peak",  o_pm1_peak,          head.peak[0]);
                check_field("pm25_mean", o_pm25_mean,         head.mean[1]);
                check_field("pm25_peak", o_pm25_peak,         head.peak[1]);
                check_field("pm10_mean", o_pm10_mean,         head.mean[2]);
                check_field("pm10_peak", o_pm10_peak,         head.peak[2]);
                if (head.kind == KIND_SUMMARY)        n_summary++;
                else if (head.status == FS_ACCEPTED)  n_good++;
                else if (head.status == FS_MISMATCH)  n_bad++;
                else                                  n_abort++;
            end
        end
    end

    // Hard stop if the run hangs.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // -------------------------------------------------------------------------
    // Tests
    // -------------------------------------------------------------------------

    // Close an empty window, abort with nothing to drop, send the spare code.
    task automatic test_idle_window();
        send_beat(OP_CLOSE, 8'hFF);
        send_beat(OP_ABORT, 8'h00);
        send_beat(OP_SPARE, 8'hA5);
        send_beat(OP_SPARE, 8'h5A);
        send_beat(OP_ABORT, 8'hFF);
        send_beat(OP_CLOSE, 8'h00);
        wait_for_results();
    endtask

    // Good frames at both value extremes, a bad checksum, an abort, a close.
    task automatic test_frame_outcomes();
        send_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 8'hFF, -1);
        send_frame(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 8'h00, -1);
        send_frame(16'h1234, 16'h0011, 16'h0022, 16'h0033, 1'b1, 1'b1, 8'h00, -1);
        repeat (5) send_beat(OP_BYTE, 8'($urandom));
        send_beat(OP_ABORT, 8'h00);
        send_beat(OP_CLOSE, 8'h00);
        wait_for_results();
    endtask

    // A close in the middle of a frame must not disturb that frame.
    task automatic test_close_mid_frame();
        send_frame(16'hBEEF, 16'h0100, 16'h0200, 16'h0300, 1'b0, 1'b1, 8'h00, 12);
        send_beat(OP_CLOSE, 8'h00);
        wait_for_results();
    endtask

    // Past 255 samples the sums freeze while peaks and id still move.
    task automatic test_count_saturation();
        for (int i = 0; i < 260; i++) begin
            if (i < 255)
                send_frame(16'(i), 16'hFFFF, 16'($urandom_range(16'h7FFF)), 16'h0000,
                           1'b0, 1'b1, 8'h00, -1);
            else
                send_frame(16'hC000 + 16'(i), 16'h0001, 16'hFFFF, 16'hFFFF,
                           1'b0, 1'b1, 8'h00, -1);
        end
        send_beat(OP_CLOSE, 8'h00);
        wait_for_results();
    endtask

    // Stall the receiver while results pile up; full must hold off the sender.
    task automatic test_backpressure();
        @(negedge i_clk);
        push <= 1'b0;
        rx_hold = HOLD_CYCLES;
        for (int i = 0; i < 12; i++) begin
            send_beat(OP_CLOSE, 8'($urandom));
            send_frame(16'($urandom), rand_pm(), rand_pm(), rand_pm(),
                       $urandom_range(3) == 0, 1'b1, 8'h00, -1);
        end
        wait_for_results();
    endtask

    // Mostly well-formed frames with random content, plus noise and broken frames.
    task automatic test_random_traffic();
        int start;
        int pick;
        int close_at;
        int n;
        start     = items_sent;
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        while (items_sent < start + RANDOM_ITEMS) begin
            if (items_sent >= start + STEADY_ITEMS) begin
                tx_steady = 1'b0;
                rx_steady = 1'b0;
            end
            pick = $urandom_range(99);
            if (pick < 70) begin
                close_at = -1;
                if ($urandom_range(19) == 0) close_at = $urandom_range(FRAME_BYTES - 2);
                send_frame(16'($urandom), rand_pm(), rand_pm(), rand_pm(),
                           $urandom_range(9) < 2, 1'b1, 8'h00, close_at);
            end else if (pick < 78) begin
                n = $urandom_range(1, FRAME_BYTES - 2);
                repeat (n) send_beat(OP_BYTE, 8'($urandom));
                send_beat(OP_ABORT, 8'($urandom));
            end else if (pick < 86) begin
                send_beat(OP_CLOSE, 8'($urandom));
            end else if (pick < 90) begin
                send_beat(OP_ABORT, 8'($urandom));
            end else if (pick < 94) begin
                send_beat(OP_SPARE, 8'($urandom));
            end else begin
                // Raw noise: mostly bytes, some of any code, then often resync.
                n = $urandom_range(1, 40);
                repeat (n) begin
                    if ($urandom_range(9) == 0) send_beat(2'($urandom), 8'($urandom));
                    else                        send_beat(OP_BYTE, 8'($urandom));
                end
                if (frm_pos != '0 && $urandom_range(1) == 1)
                    send_beat(OP_ABORT, 8'($urandom));
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        wait_for_results();
    endtask

    initial begin
        // Hold reset, then release it at a falling edge.
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_window();
        test_frame_outcomes();
        test_close_mid_frame();
        test_count_saturation();
        test_backpressure();
        test_random_traffic();

        $display("covered %0d beats: %0d good frames, %0d bad checksums, %0d aborts,",
                 items_sent, n_good, n_bad, n_abort);
        $display("%0d window summaries incl. saturated count and long stall, %0d mismatches",
                 n_summary, mismatches);
        if (mismatches == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
